/* src/ppc_pkg.sv */
// ----------------------------------------------------------------------------
// Pairwise Pearson correlation package
// Shared constants, sequencer states, multiply operations and status codes.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Default capacity of the spectrum store.
  localparam int unsigned MaxSpectraDef = 8;
  localparam int unsigned MaxBinsDef    = 1024;

  // Number of fraction bits formed by the divider before rounding.
  localparam int unsigned DivBits = 16;

  // Coefficient of the diagonal and the positive saturation value.
  localparam logic [15:0] CoefOne = 16'h7FFF;

  // Rounded magnitude that stands for a ratio of one or more.
  localparam logic [16:0] RndFull = 17'h08000;

  // Configuration value after reset.
  localparam logic [3:0] NumSpectraRst = 4'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ACC,
    S_MLOAD,
    S_MRUN,
    S_MDONE,
    S_SQLOAD,
    S_SQRUN,
    S_DLOAD,
    S_DRUN,
    S_WRITE,
    S_EMIT,
    S_MISMATCH
  } state_e;

  // Products formed by the shared shift-add multiplier, in order.
  typedef enum logic [2:0] {
    OP_MSXX,
    OP_SXSX,
    OP_MSYY,
    OP_SYSY,
    OP_MSXY,
    OP_SXSY,
    OP_RXRY
  } mul_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_UNDEF    = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

endpackage

/* src/pairwise_pearson_correlation.sv */
// ----------------------------------------------------------------------------
// Pairwise Pearson correlation
// Stores spectra bin by bin and, when spectrum 0's list ends, emits the
// correlation matrix of the first num_spectra spectra, or one mismatch item.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  bins     | in        | start, busy               | spectrum_i, weight_i,
//           |           |                           | last_i
//  config   | in        | cfg_valid_i, cfg_ready_o  | cfg_data_i
//  results  | out       | result_strobe_o           | coefficient_o, row_o,
//           |           |                           | column_o, status_o,
//           |           |                           | end_of_run_o
//
// A bin item is taken while the block is not busy and written to the store at
// once. The last bin of spectrum 0 starts a run: a length check, then per pair
// an accumulation over the store's two read ports, seven shift-add multiplies,
// two square roots, a division on the shared unit and a table write (pairs
// with zero variance skip the last multiply, the roots and the division),
// then the matrix entries row by row. SW is 16 + clog2(MAX_BINS + 1).
// Reset clears control state and lengths; the stores need no clearing.
// Results are shown for one cycle and cannot be held.
module pairwise_pearson_correlation
  import ppc_pkg::*;
#(
  parameter int unsigned MAX_SPECTRA = MaxSpectraDef,
  parameter int unsigned MAX_BINS    = MaxBinsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         spectrum_i,
  input  logic [15:0]        weight_i,
  input  logic               last_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i,
  output logic               result_strobe_o,
  output logic signed [15:0] coefficient_o,
  output logic [2:0]         row_o,
  output logic [2:0]         column_o,
  output logic [1:0]         status_o,
  output logic               end_of_run_o
);

  localparam int BW  = $clog2(MAX_BINS + 1);
  localparam int SPW = $clog2(MAX_SPECTRA);
  localparam int NW  = $clog2(MAX_SPECTRA + 1);
  localparam int AW  = $clog2(MAX_SPECTRA * MAX_BINS);
  localparam int SW  = 16 + BW;
  localparam int QW  = 32 + BW;
  localparam int PW  = 32 + 2 * BW;
  localparam int CW  = $clog2(SW + 1);
  localparam int TW  = 2 * SPW;

  state_e state_q, state_d;

  // Configuration and per-spectrum bookkeeping.
  logic [3:0]             ncfg_q;
  logic [NW-1:0]          n_q;
  logic [NW-1:0]          n_clamp;
  logic [BW-1:0]          wpos_q [MAX_SPECTRA];
  logic [BW-1:0]          len_q  [MAX_SPECTRA];
  logic [MAX_SPECTRA-1:0] tpend_q;
  logic [MAX_SPECTRA-1:0] tdone_q;

  // Bin loading.
  logic          ld;
  logic [SPW-1:0] sidx;
  logic [BW-1:0] cur_pos;
  logic          room;
  logic [BW-1:0] new_pos;
  logic [AW-1:0] waddr;
  logic          go_compute;
  logic          mis;

  // Store and accumulation pipeline.
  logic [15:0]    store [MAX_SPECTRA * MAX_BINS];
  logic [AW-1:0]  ra, rb;
  logic [15:0]    xr_q, yr_q;
  logic           issue;
  logic           v1_q, v2_q;
  logic [31:0]    xx_q, yy_q, xy_q;
  logic [15:0]    xd_q, yd_q;
  logic [SW-1:0]  sx_q, sy_q;
  logic [QW-1:0]  sxx_q, syy_q, sxy_q;
  logic [SPW-1:0] a_q, b_q;
  logic [BW-1:0]  m_q, k_q;
  logic           more_pairs;

  // Shared arithmetic unit.
  mul_op_e        op_q;
  logic [CW-1:0]  cnt_q;
  logic [PW-1:0]  mul_a_q, ma;
  logic [SW-1:0]  mul_b_q, mb;
  logic [PW-1:0]  acc_q;
  logic [PW-1:0]  tmp_q, vx_q, vy_q, mag_q, d_q;
  logic           neg_q;
  logic           zv;
  logic [PW-1:0]  sq_v_q, sq_res_q, sq_bit_q, sq_sum, sq_res_nx;
  logic           sq_ge;
  logic           sqph_q;
  logic [SW-1:0]  rx_q, ry_q;
  logic [PW:0]    r_q, r2;
  logic           dge;
  logic [15:0]    bits_q, bits_nx;
  logic [16:0]    rnd_q;
  logic [16:0]    rnd_neg;
  logic [15:0]    coef_w;
  logic [1:0]     stat_w;

  // Correlation table and result stage.
  logic [17:0]    tab [2**TW];
  logic [17:0]    tab_rd_q;
  logic [SPW-1:0] i_q, j_q, lo, hi;
  logic           endc;
  logic           em_v_q, em_diag_q, em_end_q, em_mis_q;
  logic [SPW-1:0] em_row_q, em_col_q;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;

  // Load side: one bin per accepted item.
  assign ld         = start && !busy && (32'(spectrum_i) < MAX_SPECTRA);
  assign sidx       = SPW'(spectrum_i);
  assign cur_pos    = wpos_q[sidx];
  assign room       = cur_pos < BW'(MAX_BINS);
  assign new_pos    = room ? cur_pos + BW'(1) : cur_pos;
  assign waddr      = AW'(32'(sidx) * MAX_BINS + 32'(cur_pos));
  assign go_compute = ld && last_i && (spectrum_i == 3'd0);

  // Register value clamped to the supported number of spectra.
  always_comb begin
    if (ncfg_q < 4'd2) begin
      n_clamp = NW'(2);
    end else if (32'(ncfg_q) > MAX_SPECTRA) begin
      n_clamp = NW'(MAX_SPECTRA);
    end else begin
      n_clamp = NW'(ncfg_q);
    end
  end

  // Length check over the spectra in use.
  always_comb begin
    mis = 1'b0;
    for (int s = 1; s < MAX_SPECTRA; s++) begin
      if (s < 32'(n_q) && len_q[s] != len_q[0]) mis = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncfg_q  <= NumSpectraRst;
      n_q     <= NW'(2);
      tpend_q <= '0;
      tdone_q <= '0;
      for (int s = 0; s < MAX_SPECTRA; s++) begin
        wpos_q[s] <= '0;
        len_q[s]  <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) ncfg_q <= cfg_data_i;
      if (go_compute) n_q <= n_clamp;
      if (ld) begin
        if (last_i) begin
          len_q[sidx]   <= new_pos;
          tdone_q[sidx] <= tpend_q[sidx] | !room;
          wpos_q[sidx]  <= '0;
          tpend_q[sidx] <= 1'b0;
        end else begin
          wpos_q[sidx] <= new_pos;
          if (!room) tpend_q[sidx] <= 1'b1;
        end
      end
    end
  end

  // Spectrum store: one write port, two registered read ports.
  assign issue = (state_q == S_ACC) && (k_q != m_q);
  assign ra    = AW'(32'(a_q) * MAX_BINS + 32'(k_q));
  assign rb    = AW'(32'(b_q) * MAX_BINS + 32'(k_q));

  always_ff @(posedge clk_i) begin
    if (ld && room) store[waddr] <= weight_i;
    xr_q <= store[ra];
    yr_q <= store[rb];
  end

  // Products of one bin pair, registered before the sums.
  always_ff @(posedge clk_i) begin
    xx_q <= 32'(xr_q) * 32'(xr_q);
    yy_q <= 32'(yr_q) * 32'(yr_q);
    xy_q <= 32'(xr_q) * 32'(yr_q);
    xd_q <= xr_q;
    yd_q <= yr_q;
  end

  // Operands of the shared multiplier.
  always_comb begin
    unique case (op_q)
      OP_MSXX: begin ma = PW'(sxx_q); mb = SW'(m_q); end
      OP_SXSX: begin ma = PW'(sx_q);  mb = sx_q;     end
      OP_MSYY: begin ma = PW'(syy_q); mb = SW'(m_q); end
      OP_SYSY: begin ma = PW'(sy_q);  mb = sy_q;     end
      OP_MSXY: begin ma = PW'(sxy_q); mb = SW'(m_q); end
      OP_SXSY: begin ma = PW'(sx_q);  mb = sy_q;     end
      OP_RXRY: begin ma = PW'(rx_q);  mb = ry_q;     end
      default: begin ma = '0;         mb = '0;       end
    endcase
  end

  // One step of the square root and of the divider.
  assign sq_sum    = sq_res_q + sq_bit_q;
  assign sq_ge     = sq_v_q >= sq_sum;
  assign sq_res_nx = sq_ge ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;
  assign r2        = r_q << 1;
  assign dge       = r2 >= {1'b0, d_q};
  assign bits_nx   = {bits_q[14:0], dge};
  assign zv        = (vx_q == '0) || (vy_q == '0);

  // Coefficient and status of the finished pair.
  assign rnd_neg = 17'h10000 - rnd_q;
  always_comb begin
    if (zv) begin
      coef_w = '0;
      stat_w = ST_UNDEF;
    end else begin
      if (neg_q) begin
        coef_w = rnd_neg[15:0];
      end else if (rnd_q > 17'(CoefOne)) begin
        coef_w = CoefOne;
      end else begin
        coef_w = rnd_q[15:0];
      end
      stat_w = (tdone_q[a_q] || tdone_q[b_q]) ? ST_TRUNC : ST_OK;
    end
  end

  assign more_pairs = (32'(b_q) + 1 < 32'(n_q)) || (32'(a_q) + 2 < 32'(n_q));

  // Matrix walk for the result stage.
  assign lo   = (i_q < j_q) ? i_q : j_q;
  assign hi   = (i_q < j_q) ? j_q : i_q;
  assign endc = (n_q == NW'(2)) ||
                ((32'(i_q) + 1 == 32'(n_q)) && (32'(j_q) + 1 == 32'(n_q)));

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (go_compute) state_d = S_CHECK;
      S_CHECK:    state_d = mis ? S_MISMATCH : S_ACC;
      S_MISMATCH: state_d = S_IDLE;
      S_ACC: begin
        if (k_q == m_q && !v1_q && !v2_q) state_d = S_MLOAD;
      end
      S_MLOAD:    state_d = S_MRUN;
      S_MRUN:     if (cnt_q == CW'(SW - 1)) state_d = S_MDONE;
      S_MDONE: begin
        unique case (op_q)
          OP_SXSY: state_d = zv ? S_WRITE : S_SQLOAD;
          OP_RXRY: state_d = S_DLOAD;
          default: state_d = S_MLOAD;
        endcase
      end
      S_SQLOAD:   state_d = S_SQRUN;
      S_SQRUN: begin
        if (cnt_q == CW'(SW - 1)) state_d = sqph_q ? S_MLOAD : S_SQLOAD;
      end
      S_DLOAD:    state_d = (mag_q >= d_q) ? S_WRITE : S_DRUN;
      S_DRUN:     if (cnt_q == CW'(DivBits - 1)) state_d = S_WRITE;
      S_WRITE:    state_d = more_pairs ? S_ACC : S_EMIT;
      S_EMIT:     if (endc) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Pipeline and result valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      em_v_q <= 1'b0;
    end else begin
      v1_q   <= issue;
      v2_q   <= v1_q;
      em_v_q <= (state_q == S_EMIT) || (state_q == S_MISMATCH);
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_CHECK: begin
        a_q   <= '0;
        b_q   <= SPW'(1);
        m_q   <= len_q[0];
        k_q   <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
        op_q  <= OP_MSXX;
      end
      S_ACC: begin
        if (issue) k_q <= k_q + BW'(1);
        if (v2_q) begin
          sx_q  <= sx_q + SW'(xd_q);
          sy_q  <= sy_q + SW'(yd_q);
          sxx_q <= sxx_q + QW'(xx_q);
          syy_q <= syy_q + QW'(yy_q);
          sxy_q <= sxy_q + QW'(xy_q);
        end
      end
      S_MLOAD: begin
        mul_a_q <= ma;
        mul_b_q <= mb;
        acc_q   <= '0;
        cnt_q   <= '0;
      end
      S_MRUN: begin
        if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
        mul_a_q <= mul_a_q << 1;
        mul_b_q <= mul_b_q >> 1;
        cnt_q   <= cnt_q + CW'(1);
      end
      S_MDONE: begin
        unique case (op_q)
          OP_MSXX: begin tmp_q <= acc_q; op_q <= OP_SXSX; end
          OP_SXSX: begin vx_q <= tmp_q - acc_q; op_q <= OP_MSYY; end
          OP_MSYY: begin tmp_q <= acc_q; op_q <= OP_SYSY; end
          OP_SYSY: begin vy_q <= tmp_q - acc_q; op_q <= OP_MSXY; end
          OP_MSXY: begin tmp_q <= acc_q; op_q <= OP_SXSY; end
          OP_SXSY: begin
            neg_q  <= tmp_q < acc_q;
            mag_q  <= (tmp_q < acc_q) ? acc_q - tmp_q : tmp_q - acc_q;
            sqph_q <= 1'b0;
            op_q   <= OP_RXRY;
          end
          OP_RXRY: d_q <= acc_q;
          default: d_q <= acc_q;
        endcase
      end
      S_SQLOAD: begin
        sq_v_q   <= sqph_q ? vy_q : vx_q;
        sq_res_q <= '0;
        sq_bit_q <= PW'(1) << (PW - 2);
        cnt_q    <= '0;
      end
      S_SQRUN: begin
        if (sq_ge) sq_v_q <= sq_v_q - sq_sum;
        sq_res_q <= sq_res_nx;
        sq_bit_q <= sq_bit_q >> 2;
        cnt_q    <= cnt_q + CW'(1);
        if (cnt_q == CW'(SW - 1)) begin
          if (sqph_q) ry_q <= SW'(sq_res_nx);
          else        rx_q <= SW'(sq_res_nx);
          sqph_q <= ~sqph_q;
        end
      end
      S_DLOAD: begin
        r_q    <= {1'b0, mag_q};
        bits_q <= '0;
        cnt_q  <= '0;
        rnd_q  <= RndFull;
      end
      S_DRUN: begin
        r_q    <= dge ? r2 - {1'b0, d_q} : r2;
        bits_q <= bits_nx;
        cnt_q  <= cnt_q + CW'(1);
        rnd_q  <= (17'(bits_nx) + 17'd1) >> 1;
      end
      S_WRITE: begin
        tab[{a_q, b_q}] <= {stat_w, coef_w};
        if (32'(b_q) + 1 < 32'(n_q)) begin
          b_q <= b_q + SPW'(1);
        end else begin
          a_q <= a_q + SPW'(1);
          b_q <= a_q + SPW'(2);
        end
        k_q   <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
        op_q  <= OP_MSXX;
        i_q   <= '0;
        j_q   <= (n_q == NW'(2)) ? SPW'(1) : SPW'(0);
      end
      S_EMIT: begin
        if (32'(j_q) + 1 == 32'(n_q)) begin
          j_q <= '0;
          i_q <= i_q + SPW'(1);
        end else begin
          j_q <= j_q + SPW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Table read and result stage.
  always_ff @(posedge clk_i) begin
    tab_rd_q <= tab[{lo, hi}];
    if (state_q == S_MISMATCH) begin
      em_row_q  <= '0;
      em_col_q  <= '0;
      em_diag_q <= 1'b0;
      em_end_q  <= 1'b1;
      em_mis_q  <= 1'b1;
    end else begin
      em_row_q  <= i_q;
      em_col_q  <= j_q;
      em_diag_q <= (i_q == j_q);
      em_end_q  <= endc;
      em_mis_q  <= 1'b0;
    end
  end

  // Result ports.
  assign result_strobe_o = em_v_q;
  assign row_o           = 3'(em_row_q);
  assign column_o        = 3'(em_col_q);
  assign end_of_run_o    = em_v_q && em_end_q;
  always_comb begin
    if (em_mis_q) begin
      coefficient_o = '0;
      status_o      = ST_MISMATCH;
    end else if (em_diag_q) begin
      coefficient_o = CoefOne;
      status_o      = tdone_q[em_row_q] ? ST_TRUNC : ST_OK;
    end else begin
      coefficient_o = tab_rd_q[15:0];
      status_o      = tab_rd_q[17:16];
    end
  end

`ifndef SYNTHESIS
  // The last bin of spectrum 0 starts a run.
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && spectrum_i == 3'd0 && last_i) |=> busy)
    else $error("run did not start after the last bin of spectrum 0");

  // A run's final result is followed by a quiet cycle.
  a_end_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && end_of_run_o) |=> !result_strobe_o)
    else $error("result after the end of a run");

  // A length mismatch is reported as a single closing item.
  a_mis_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && status_o == ST_MISMATCH) |-> end_of_run_o)
    else $error("mismatch result does not end the run");

  // Diagonal entries carry a coefficient of one.
  a_diag_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && row_o == column_o && status_o != ST_MISMATCH)
    |-> coefficient_o == CoefOne)
    else $error("diagonal coefficient is not one");
`endif

endmodule
